// File: rtl/skm_pkg.sv
// package for the serial command keyword matcher: keyword table, codes and types
`timescale 1ns / 1ps

package skm_pkg;

    localparam int KW_COUNT      = 8;
    localparam int KW_SLOTS      = 24;
    localparam int KW_IDX_W      = 3;
    localparam int KW_LEN_W      = 5;
    localparam int LINE_LEN_W    = 8;
    localparam int LINE_CAP_DEF  = 128;

    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_HYPHEN     = 8'h2D;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CHAR_DIGIT_LO   = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_HI   = 8'h39;
    localparam logic [7:0] CHAR_UPPER_LO   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_HI   = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_LO   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_HI   = 8'h7A;

    typedef enum logic [1:0] {
        STATUS_MATCH    = 2'd0,
        STATUS_NO_MATCH = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } line_status_t;

    typedef enum logic [KW_IDX_W-1:0] {
        CMD_ARM_ENABLE   = 3'd0,
        CMD_ARM_DISABLE  = 3'd1,
        CMD_3V3_ENABLE   = 3'd2,
        CMD_3V3_DISABLE  = 3'd3,
        CMD_5V_ENABLE    = 3'd4,
        CMD_5V_DISABLE   = 3'd5,
        CMD_VBAT_ENABLE  = 3'd6,
        CMD_VBAT_DISABLE = 3'd7
    } command_t;

    typedef struct packed {
        logic                valid;
        line_status_t        status;
        logic [KW_IDX_W-1:0] index;
    } skm_result_t;

    // keyword text, right-justified, last character in the low byte
    function automatic logic [KW_SLOTS*8-1:0] kw_text(input command_t k);
        logic [KW_SLOTS*8-1:0] t;
        unique case (k)
            CMD_ARM_ENABLE:   t = "\\arm-enable";
            CMD_ARM_DISABLE:  t = "\\arm-disable";
            CMD_3V3_ENABLE:   t = "\\voltage-3v3-enable";
            CMD_3V3_DISABLE:  t = "\\voltage-3v3-disable";
            CMD_5V_ENABLE:    t = "\\voltage-5v-enable";
            CMD_5V_DISABLE:   t = "\\voltage-5v-disable";
            CMD_VBAT_ENABLE:  t = "\\voltage-vbat-enable";
            CMD_VBAT_DISABLE: t = "\\voltage-vbat-disable";
            default:          t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [KW_LEN_W-1:0] kw_len(input command_t k);
        logic [KW_LEN_W-1:0] n;
        unique case (k)
            CMD_ARM_ENABLE:   n = 5'd11;
            CMD_ARM_DISABLE:  n = 5'd12;
            CMD_3V3_ENABLE:   n = 5'd19;
            CMD_3V3_DISABLE:  n = 5'd20;
            CMD_5V_ENABLE:    n = 5'd18;
            CMD_5V_DISABLE:   n = 5'd19;
            CMD_VBAT_ENABLE:  n = 5'd20;
            CMD_VBAT_DISABLE: n = 5'd21;
            default:          n = '0;
        endcase
        return n;
    endfunction

    function automatic logic is_line_char(input logic [7:0] c);
        return (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) ||
               (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) ||
               (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) ||
               c == CHAR_HYPHEN || c == CHAR_UNDERSCORE || c == CHAR_BACKSLASH;
    endfunction

endpackage

// File: rtl/skm_line_tracker.sv
// line state and per-keyword character compare for one received byte
`timescale 1ns / 1ps

module skm_line_tracker
    import skm_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAP_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  rx_char,
    output skm_result_t result
);

    logic [LINE_LEN_W-1:0] line_length_reg;
    logic [LINE_LEN_W-1:0] line_length_next;
    logic [KW_COUNT-1:0]   cand_mask_reg;
    logic [KW_COUNT-1:0]   cand_mask_next;

    logic                  line_full;
    logic [KW_COUNT-1:0]   char_hit;
    logic [KW_COUNT-1:0]   len_hit;

    assign line_full = line_length_reg >= LINE_LEN_W'(LINE_CAPACITY);

    // per keyword: does this character fit at the current position, and does the length match
    always_comb
    begin
        logic [KW_SLOTS*8-1:0] text;
        logic [KW_LEN_W-1:0]   klen;
        logic [LINE_LEN_W-1:0] offset;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            text   = kw_text(command_t'(k));
            klen   = kw_len(command_t'(k));
            offset = LINE_LEN_W'(klen) - LINE_LEN_W'(1) - line_length_reg;
            char_hit[k] = (line_length_reg < LINE_LEN_W'(klen)) &&
                          (text[{offset[KW_LEN_W-1:0], 3'b000} +: 8] == rx_char);
            len_hit[k]  = (LINE_LEN_W'(klen) == line_length_reg);
        end
    end

    always_comb
    begin
        line_length_next = line_length_reg;
        cand_mask_next   = cand_mask_reg;
        result.valid     = 1'b0;
        result.status    = STATUS_NO_MATCH;
        result.index     = '0;
        if (rx_char == CHAR_CR)
        begin
            result.valid     = 1'b1;
            line_length_next = '0;
            cand_mask_next   = '1;
            if (line_full)
            begin
                result.status = STATUS_OVERFLOW;
            end
            else
            begin
                for (int k = KW_COUNT - 1; k >= 0; k--)
                begin
                    if (cand_mask_reg[k] && len_hit[k])
                    begin
                        result.status = STATUS_MATCH;
                        result.index  = KW_IDX_W'(k);
                    end
                end
            end
        end
        else if (is_line_char(rx_char))
        begin
            if (line_full)
            begin
                line_length_next = '0;
                cand_mask_next   = '1;
            end
            else
            begin
                line_length_next = line_length_reg + LINE_LEN_W'(1);
                cand_mask_next   = cand_mask_reg & char_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= '0;
            cand_mask_reg   <= '1;
        end
        else if (advance)
        begin
            line_length_reg <= line_length_next;
            cand_mask_reg   <= cand_mask_next;
        end
    end

endmodule

// File: rtl/serial_command_keyword_matcher.sv
// top level: input register, line tracker and registered result
//
// usage: raw received bytes enter on rx_byte with rx_valid / rx_ready; a result
// leaves on line_status / command_index with result_valid / result_ready.
// only a carriage return yields a result: status 0 with the command index on
// a keyword match, 1 for no match (also an empty line), 2 when the line held
// LINE_CAPACITY characters and was discarded. bytes other than digits,
// letters, hyphen, underscore and backslash are dropped without a result.
// a byte is accepted in every cycle unless rx_ready is low; it passes through
// the input register, and its result, if any, is then loaded into the result
// register when the tracker stage fires.
// throughput is one item per cycle while no carriage return waits on a full
// result register, set by the input register feeding the tracker state update.
// when result_ready is low with a result waiting, the input register keeps
// taking bytes that give no result; a carriage return waits there and
// rx_ready drops until the result register frees up.
// reset clears the line: length zero, every keyword still possible, both
// registers empty.
`timescale 1ns / 1ps

module serial_command_keyword_matcher
    import skm_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAP_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  logic [7:0]          rx_byte,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [1:0]          line_status,
    output logic [KW_IDX_W-1:0] command_index
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                out_valid_reg;
    line_status_t        out_status_reg;
    logic [KW_IDX_W-1:0] out_index_reg;

    skm_result_t         res;
    logic                out_free;
    logic                stage_fire;

    skm_line_tracker #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (stage_fire),
        .rx_char (in_byte_reg),
        .result  (res)
    );

    assign out_free   = !out_valid_reg || result_ready;
    assign stage_fire = in_valid_reg && (!res.valid || out_free);
    assign rx_ready   = !in_valid_reg || stage_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_ready)
        begin
            in_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire && res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && res.valid)
        begin
            out_status_reg <= res.status;
            out_index_reg  <= res.index;
        end
    end

    assign result_valid  = out_valid_reg;
    assign line_status   = out_status_reg;
    assign command_index = out_index_reg;

endmodule

// File: dv/tb_serial_command_keyword_matcher.sv
// testbench for the serial command keyword matcher: directed command lines, then random traffic
`timescale 1ns / 1ps

module tb_serial_command_keyword_matcher;
    import skm_pkg::*;

    localparam int LINE_CAP     = LINE_CAP_DEF;
    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        line_status_t status;
        command_t     index;
    } verdict_t;

    typedef struct {
        logic [7:0]   fill;
        int           reps;
        string        text;
        bit           typed;
        line_status_t status;
        command_t     index;
    } vector_row_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                rx_valid     = 1'b0;
    logic                rx_ready;
    logic [7:0]          rx_byte      = 8'h00;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic [1:0]          line_status;
    logic [KW_IDX_W-1:0] command_index;

    string cmd_text [KW_COUNT] = '{
        "\\arm-enable",
        "\\arm-disable",
        "\\voltage-3v3-enable",
        "\\voltage-3v3-disable",
        "\\voltage-5v-enable",
        "\\voltage-5v-disable",
        "\\voltage-vbat-enable",
        "\\voltage-vbat-disable"
    };

    // fill bytes are sent reps times, then the text
    vector_row_t plan [20] = '{
        '{8'h00, 0, "\015", 1'b1, STATUS_NO_MATCH, CMD_ARM_ENABLE},
        '{8'h00, 1, "", 1'b0, STATUS_MATCH, CMD_ARM_ENABLE},
        '{8'hFF, 1, "", 1'b0, STATUS_MATCH, CMD_ARM_ENABLE},
        '{8'h00, 0, "\\arm-enable\015", 1'b1, STATUS_MATCH, CMD_ARM_ENABLE},
        '{8'h00, 0, "\\arm-disable\015", 1'b1, STATUS_MATCH, CMD_ARM_DISABLE},
        '{8'h00, 0, "\\voltage-3v3-enable\015", 1'b1, STATUS_MATCH, CMD_3V3_ENABLE},
        '{8'h00, 0, "\\voltage-3v3-disable\015", 1'b1, STATUS_MATCH, CMD_3V3_DISABLE},
        '{8'h00, 0, "\\voltage-5v-enable\015", 1'b1, STATUS_MATCH, CMD_5V_ENABLE},
        '{8'h00, 0, "\\voltage-5v-disable\015", 1'b1, STATUS_MATCH, CMD_5V_DISABLE},
        '{8'h00, 0, "\\voltage-vbat-enable\015", 1'b1, STATUS_MATCH, CMD_VBAT_ENABLE},
        '{8'h00, 0, "\\voltage-vbat-disable\015", 1'b1, STATUS_MATCH, CMD_VBAT_DISABLE},
        '{8'h00, 0, "\\arm-enabl\015", 1'b1, STATUS_NO_MATCH, CMD_ARM_ENABLE},
        '{8'h00, 0, "\\arm-enablee\015", 1'b1, STATUS_NO_MATCH, CMD_ARM_ENABLE},
        '{8'h00, 0, "\\ARM-ENABLE\015", 1'b1, STATUS_NO_MATCH, CMD_ARM_ENABLE},
        '{8'h00, 0, "\\arm\001-en\377able\015", 1'b0, STATUS_MATCH, CMD_ARM_ENABLE},
        '{8'h00, 0, "/0:9@A[Z\140a{z_\015", 1'b0, STATUS_MATCH, CMD_ARM_ENABLE},
        '{"z", LINE_CAP, "\015", 1'b1, STATUS_OVERFLOW, CMD_ARM_ENABLE},
        '{"_", LINE_CAP - 1, "\015", 1'b1, STATUS_NO_MATCH, CMD_ARM_ENABLE},
        '{"9", LINE_CAP + 1, "\\voltage-vbat-disable\015", 1'b0, STATUS_MATCH,
          CMD_ARM_ENABLE},
        '{"-", LINE_CAP, "\\\\arm-enable\015", 1'b0, STATUS_MATCH, CMD_ARM_ENABLE}
    };

    logic [7:0] line_len  = 8'd0;
    logic [7:0] live_mask = 8'hFF;
    verdict_t   pending_verdicts [$];
    int         failures  = 0;
    int         cycles    = 0;
    int         sent      = 0;
    bit         steady    = 1'b0;

    serial_command_keyword_matcher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_ready      (rx_ready),
        .rx_byte       (rx_byte),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .line_status   (line_status),
        .command_index (command_index)
    );

    always #5 clk = ~clk;

    function automatic bit is_cmd_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == "-" || c == "_" || c == "\\";
    endfunction

    function automatic logic [7:0] random_cmd_char();
        int r;
        r = $urandom_range(0, 64);
        if (r < 10)
            return CHAR_DIGIT_LO + 8'(r);
        if (r < 36)
            return CHAR_UPPER_LO + 8'(r - 10);
        if (r < 62)
            return CHAR_LOWER_LO + 8'(r - 36);
        if (r == 62)
            return CHAR_HYPHEN;
        if (r == 63)
            return CHAR_UNDERSCORE;
        return CHAR_BACKSLASH;
    endfunction

    // updates the line state for one byte, returns 1 when the byte closes a line
    function automatic bit advance_line(input logic [7:0] c, output verdict_t v);
        int k;
        v.status = STATUS_NO_MATCH;
        v.index  = CMD_ARM_ENABLE;
        if (c == CHAR_CR)
        begin
            if (line_len >= LINE_CAP)
                v.status = STATUS_OVERFLOW;
            else
                for (k = 0; k < KW_COUNT; k++)
                    if (v.status == STATUS_NO_MATCH && live_mask[k] &&
                        cmd_text[k].len() == line_len)
                    begin
                        v.status = STATUS_MATCH;
                        v.index  = command_t'(k);
                    end
            line_len  = 8'd0;
            live_mask = 8'hFF;
            return 1'b1;
        end
        if (!is_cmd_char(c))
            return 1'b0;
        if (line_len >= LINE_CAP)
        begin
            line_len  = 8'd0;
            live_mask = 8'hFF;
            return 1'b0;
        end
        for (k = 0; k < KW_COUNT; k++)
            if (line_len >= cmd_text[k].len() || cmd_text[k][line_len] != c)
                live_mask[k] = 1'b0;
        line_len = line_len + 8'd1;
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input line_status_t status, input command_t index);
        verdict_t v;
        if (!steady)
            while ($urandom_range(0, 99) < 11)
            begin
                rx_valid <= 1'b0;
                @(posedge clk);
            end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!rx_ready);
        sent++;
        if (advance_line(b, v))
        begin
            if (typed)
            begin
                v.status = status;
                v.index  = index;
            end
            pending_verdicts.push_back(v);
        end
    endtask

    task automatic drain_results();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int         i;
        int         k;
        int         p;
        int         n;
        int         pick;
        bit         drained;
        logic [7:0] ch;
        logic [7:0] burst [$];

        drained = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
        begin
            repeat (plan[r].reps)
                send_byte(plan[r].fill, plan[r].typed, plan[r].status, plan[r].index);
            for (i = 0; i < plan[r].text.len(); i++)
                send_byte(plan[r].text[i], plan[r].typed, plan[r].status, plan[r].index);
        end
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady = (sent >= 60 && sent < 190);
            if (!drained && sent >= 220)
            begin
                drain_results();
                drained = 1'b1;
            end
            burst.delete();
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, KW_COUNT - 1);
            if (pick < 45)
            begin
                // clean keyword, now and then with ignored bytes mixed in
                for (i = 0; i < cmd_text[k].len(); i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        ch = 8'($urandom_range(0, 255));
                        while (ch == CHAR_CR || is_cmd_char(ch))
                            ch = 8'($urandom_range(0, 255));
                        burst.push_back(ch);
                    end
                    burst.push_back(cmd_text[k][i]);
                end
                burst.push_back(CHAR_CR);
            end
            else if (pick < 62)
            begin
                // near miss of a keyword
                for (i = 0; i < cmd_text[k].len(); i++)
                    burst.push_back(cmd_text[k][i]);
                p  = $urandom_range(0, cmd_text[k].len() - 1);
                ch = random_cmd_char();
                case ($urandom_range(0, 3))
                    0:
                    begin
                        while (ch == burst[p])
                            ch = random_cmd_char();
                        burst[p] = ch;
                    end
                    1: burst.delete(p);
                    2: burst.insert(p, ch);
                    default:
                        while (burst.size() > p)
                            void'(burst.pop_back());
                endcase
                burst.push_back(CHAR_CR);
            end
            else if (pick < 77)
            begin
                n = $urandom_range(0, 24);
                repeat (n) burst.push_back(random_cmd_char());
                burst.push_back(CHAR_CR);
            end
            else if (pick < 80)
            begin
                // line around the capacity
                n = $urandom_range(LINE_CAP - 2, LINE_CAP + 2);
                repeat (n) burst.push_back(random_cmd_char());
                if ($urandom_range(0, 1))
                    for (i = 0; i < cmd_text[k].len(); i++)
                        burst.push_back(cmd_text[k][i]);
                burst.push_back(CHAR_CR);
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n) burst.push_back(8'($urandom_range(0, 255)));
            end
            foreach (burst[j])
                send_byte(burst[j], 1'b0, STATUS_MATCH, CMD_ARM_ENABLE);
        end
        steady = 1'b0;

        drain_results();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        verdict_t want;
        result_ready <= steady || ($urandom_range(0, 99) >= 11);
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: status %0d index %0d",
                             line_status, command_index);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (line_status !== want.status || command_index !== want.index)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("mismatch: status exp %0d got %0d, index exp %0d got %0d",
                                 want.status, line_status, want.index, command_index);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
